FILE: rtl/rmsenv_pkg.sv
// Package for the RMS envelope detector: sequencer state type, register
// index codes and register reset values. No dependencies.
package rmsenv_pkg;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_COEFF  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COEFF = 2'd1;

   localparam int ATTACK_RESET  = 65062;
   localparam int RELEASE_RESET = 65523;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SQUARE = 8'b0000_0010,
      ST_CMP    = 8'b0000_0100,
      ST_DIFF   = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_UPDATE = 8'b0010_0000,
      ST_ROOT   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

endpackage

FILE: rtl/rms_envelope_detector_top.sv
// An accepted request runs the square, compare, difference, product, update, root and
// done steps before rsp_valid; req_ready is high only while the sequencer idles, so a
// new transaction is not taken until the last one has left the done step.
// One shared add/subtract unit does the compare, difference, product, mean-square update
// and bitwise square root. Synchronous active-high reset clears the mean square, the
// sequencer and rsp_valid and loads the coefficient reset values. Uses rmsenv_pkg.
module rms_envelope_detector_top
   import rmsenv_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic        [SAMPLE_BITS-1:0] rsp_rms_level,
   input  logic                          csr_write_enable,
   input  logic     [CSR_INDEX_BITS-1:0] csr_index,
   input  logic         [COEFF_BITS-1:0] csr_data
);

   localparam int MS_BITS  = 2 * SAMPLE_BITS - 1;
   localparam int ALU_BITS = 2 * SAMPLE_BITS + 1;
   localparam int MAX_STEPS = (SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS;
   localparam int CNT_BITS = $clog2(MAX_STEPS);
   localparam logic [SAMPLE_BITS-1:0] ROOT_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   state_type state_ff, state_in;

   logic [COEFF_BITS-1:0]    attack_ff, release_ff;
   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic [MS_BITS-1:0]       power_ff, ms_ff, diff_ff, acc_ff;
   logic                     attack_sel_ff, sticky_ff;
   logic [COEFF_BITS-1:0]    coef_sh_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic [2*SAMPLE_BITS-1:0] src_ff;
   logic [ALU_BITS-1:0]      rem_ff;
   logic [SAMPLE_BITS-1:0]   root_ff;
   logic                     rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]   rsp_level_ff;

   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] mag_sq;
   logic [ALU_BITS-1:0]      alu_a, alu_b, alu_sum, root_a;
   logic                     alu_sub, alu_cin, alu_neg, out_free;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rms_level = rsp_level_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   assign mag    = sample_ff[SAMPLE_BITS-1] ? (~sample_ff + 1'b1) : sample_ff;
   assign mag_sq = mag * mag;
   assign root_a = {rem_ff[ALU_BITS-3:0], src_ff[2*SAMPLE_BITS-1 -: 2]};

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      alu_cin = 1'b0;
      unique case (state_ff)
         ST_CMP: begin
            alu_a   = ALU_BITS'(power_ff);
            alu_b   = ALU_BITS'(ms_ff);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         ST_DIFF: begin
            alu_a   = attack_sel_ff ? ALU_BITS'(power_ff) : ALU_BITS'(ms_ff);
            alu_b   = attack_sel_ff ? ALU_BITS'(ms_ff) : ALU_BITS'(power_ff);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         ST_MUL: begin
            alu_a = ALU_BITS'(acc_ff);
            alu_b = coef_sh_ff[0] ? ALU_BITS'(diff_ff) : '0;
         end
         ST_UPDATE: begin
            alu_a   = ALU_BITS'(power_ff);
            alu_b   = ALU_BITS'(acc_ff);
            alu_sub = attack_sel_ff;
            alu_cin = attack_sel_ff & ~sticky_ff;
         end
         ST_ROOT: begin
            alu_a   = root_a;
            alu_b   = ALU_BITS'({root_ff, 2'b01});
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_BITS'(alu_cin);
   assign alu_neg = alu_sum[ALU_BITS-1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_CMP;
         ST_CMP:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    if (count_ff == CNT_BITS'(COEFF_BITS - 1)) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_ROOT;
         ST_ROOT:   if (count_ff == CNT_BITS'(SAMPLE_BITS - 1)) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ms_ff        <= '0;
         attack_ff    <= COEFF_BITS'(ATTACK_RESET);
         release_ff   <= COEFF_BITS'(RELEASE_RESET);
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_ATTACK_COEFF) begin
               attack_ff <= csr_data;
            end else if (csr_index == CSR_RELEASE_COEFF) begin
               release_ff <= csr_data;
            end
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_UPDATE) begin
            ms_ff <= alu_sum[MS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            sample_ff <= req_sample;
         end
         ST_SQUARE: begin
            power_ff <= mag_sq[MS_BITS-1:0];
         end
         ST_CMP: begin
            attack_sel_ff <= !alu_neg && (alu_sum != '0);
         end
         ST_DIFF: begin
            diff_ff    <= alu_sum[MS_BITS-1:0];
            coef_sh_ff <= attack_sel_ff ? attack_ff : release_ff;
            acc_ff     <= '0;
            sticky_ff  <= 1'b0;
            count_ff   <= '0;
         end
         ST_MUL: begin
            acc_ff     <= alu_sum[MS_BITS:1];
            sticky_ff  <= sticky_ff | alu_sum[0];
            coef_sh_ff <= coef_sh_ff >> 1;
            count_ff   <= count_ff + 1'b1;
         end
         ST_UPDATE: begin
            src_ff   <= {1'b0, alu_sum[MS_BITS-1:0]};
            rem_ff   <= '0;
            root_ff  <= '0;
            count_ff <= '0;
         end
         ST_ROOT: begin
            rem_ff   <= alu_neg ? root_a : alu_sum;
            root_ff  <= {root_ff[SAMPLE_BITS-2:0], !alu_neg};
            src_ff   <= src_ff << 2;
            count_ff <= count_ff + 1'b1;
         end
         ST_DONE: begin
            if (out_free) rsp_level_ff <= root_ff;
         end
         default: begin
            sample_ff <= sample_ff;
         end
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SQUARE)
      else $error("accepted transaction did not start the sequencer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> count_ff <= CNT_BITS'(COEFF_BITS - 1))
      else $error("product step count out of range");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> root_ff <= ROOT_MAX)
      else $error("square root exceeds full scale");

endmodule

FILE: tb/rmsenv_scoreboard_pkg.sv
// Scoreboard for the RMS envelope detector testbench: a bit-accurate mean-square
// smoother with attack/release coefficients and a queue of predicted RMS levels.
// Depends on rmsenv_pkg for register index codes and reset values.
package rmsenv_scoreboard_pkg;
   import rmsenv_pkg::*;

   localparam int SAMPLE_W = 24;
   localparam int COEFF_W  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   class rms_level_scoreboard;
      logic [COEFF_W-1:0]  attack_q;
      logic [COEFF_W-1:0]  release_q;
      logic [63:0]         mean_square_q;
      logic [SAMPLE_W-1:0] expected_levels[$];
      int unsigned         failures;

      function new();
         attack_q      = COEFF_W'(ATTACK_RESET);
         release_q     = COEFF_W'(RELEASE_RESET);
         mean_square_q = '0;
         failures      = 0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [COEFF_W-1:0] data);
         if (idx == CSR_ATTACK_COEFF) begin
            attack_q = data;
         end else if (idx == CSR_RELEASE_COEFF) begin
            release_q = data;
         end
      endfunction

      function logic [SAMPLE_W-1:0] floor_sqrt(input logic [63:0] x);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] bitv;
         rem  = x;
         root = '0;
         bitv = 64'd1 << 62;
         while (bitv > rem) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem  = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root[SAMPLE_W-1:0];
      endfunction

      function logic [SAMPLE_W-1:0] smooth_and_root(input logic signed [SAMPLE_W-1:0] sample);
         logic [SAMPLE_W-1:0] mag;
         logic [63:0]         power;
         logic [63:0]         prod;
         logic [63:0]         step;
         mag   = sample[SAMPLE_W-1] ? SAMPLE_W'(0) - SAMPLE_W'(sample) : SAMPLE_W'(sample);
         power = 64'(mag) * 64'(mag);
         if (power > mean_square_q) begin
            // Rising power: the product is negative, so flooring rounds its size up.
            prod = 64'(attack_q) * (power - mean_square_q);
            step = (prod >> COEFF_W) + ((prod[COEFF_W-1:0] != 0) ? 64'd1 : 64'd0);
            mean_square_q = power - step;
         end else begin
            prod = 64'(release_q) * (mean_square_q - power);
            mean_square_q = power + (prod >> COEFF_W);
         end
         return floor_sqrt(mean_square_q);
      endfunction

      function void note_sample(input logic signed [SAMPLE_W-1:0] sample);
         expected_levels.push_back(smooth_and_root(sample));
      endfunction

      function void check_level(input logic [SAMPLE_W-1:0] actual);
         logic [SAMPLE_W-1:0] expected;
         if (expected_levels.size() == 0) begin
            $error("rms_level %0d arrived with no transaction pending", actual);
            failures++;
            return;
         end
         expected = expected_levels.pop_front();
         if (actual !== expected) begin
            $error("rms_level mismatch: expected %0d, actual %0d", expected, actual);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_levels.size();
      endfunction
   endclass

endpackage

FILE: tb/rms_envelope_detector_top_tb.sv
// Top-level testbench for rms_envelope_detector_top: directed and burst-shaped
// random samples under several coefficient settings, random idling on both sides.
// Depends on rmsenv_pkg and rmsenv_scoreboard_pkg.
module rms_envelope_detector_top_tb
   import rmsenv_pkg::*, rmsenv_scoreboard_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 125;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 60;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic        [SAMPLE_W-1:0]   rsp_rms_level;
   logic                         csr_write_enable = 1'b0;
   logic        [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic        [COEFF_W-1:0]    csr_data = '0;

   bit tx_idle_en = 1'b0;
   bit rx_idle_en = 1'b0;
   int unsigned stall_cycles = 0;

   rms_level_scoreboard sb = new();

   rms_envelope_detector_top #(
      .SAMPLE_BITS(SAMPLE_W),
      .COEFF_BITS (COEFF_W)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rms_level   (rsp_rms_level),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_level(rsp_rms_level);
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable || reset) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int unsigned gap;
      bit          wait_valid;
      wait (!reset);
      forever begin
         gap        = rx_idle_en ? $urandom_range(7, 0) : 0;
         wait_valid = $urandom_range(1, 0);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            if (wait_valid) begin
               do @(posedge clock); while (!rsp_valid);
            end
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      int unsigned gap;
      gap = tx_idle_en ? $urandom_range(7, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_levels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COEFF_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [COEFF_W-1:0] pick_coeff(input logic [COEFF_W-1:0] reset_value);
      case ($urandom_range(5, 0))
         0: return '0;
         1: return '1;
         2: return reset_value;
         default: return COEFF_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int unsigned level);
      int unsigned        pick;
      logic [SAMPLE_W-1:0] mag;
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
         return SAMPLE_W'($urandom);
      end
      if (pick < 20) begin
         case ($urandom_range(4, 0))
            0: return '0;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'hFFFFFF;
            default: return 24'h000001;
         endcase
      end
      mag = SAMPLE_W'($urandom) & ((SAMPLE_W'(1) << level) - SAMPLE_W'(1));
      return $urandom_range(1, 0) ? SAMPLE_W'(0) - mag : mag;
   endfunction

   task automatic run_random_phase(input int unsigned count);
      int unsigned remaining;
      int unsigned burst;
      int unsigned level;
      remaining = count;
      while (remaining > 0) begin
         burst = $urandom_range(40, 1);
         level = $urandom_range(SAMPLE_W - 1, 0);
         while (burst > 0 && remaining > 0) begin
            send_sample(draw_sample(level));
            burst--;
            remaining--;
            if ($urandom_range(49, 0) == 0) begin
               drain_levels();
            end
         end
      end
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] defaults_set[8] = '{
         24'h000000, 24'h7FFFFF, 24'h800000, 24'h800000,
         24'hFFFFFF, 24'h000001, 24'h555555, 24'hAAAAAA
      };
      logic signed [SAMPLE_W-1:0] zero_coeff_set[6] = '{
         24'h800000, 24'h7FFFFF, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h2AAAAA
      };
      logic signed [SAMPLE_W-1:0] full_coeff_set[4] = '{
         24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (defaults_set[i]) send_sample(defaults_set[i]);
      drain_levels();

      write_csr(CSR_ATTACK_COEFF, '0);
      write_csr(CSR_RELEASE_COEFF, '0);
      foreach (zero_coeff_set[i]) send_sample(zero_coeff_set[i]);
      drain_levels();

      write_csr(CSR_ATTACK_COEFF, '1);
      write_csr(CSR_RELEASE_COEFF, '1);
      foreach (full_coeff_set[i]) send_sample(full_coeff_set[i]);
      drain_levels();

      write_csr(CSR_RELEASE_COEFF, '0);
      write_csr(CSR_SPARE_LO, COEFF_W'($urandom));
      write_csr(CSR_SPARE_HI, COEFF_W'($urandom));
      send_sample(24'sh7FFFFF);
      send_sample(24'sh000000);
      drain_levels();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         tx_idle_en = (phase == 0) ? 1'b0 : ($urandom_range(3, 0) != 0);
         rx_idle_en = (phase == 0) ? 1'b0 : ($urandom_range(3, 0) != 0);
         write_csr(CSR_ATTACK_COEFF, pick_coeff(COEFF_W'(ATTACK_RESET)));
         write_csr(CSR_RELEASE_COEFF, pick_coeff(COEFF_W'(RELEASE_RESET)));
         if ($urandom_range(2, 0) == 0) begin
            write_csr($urandom_range(1, 0) ? CSR_SPARE_LO : CSR_SPARE_HI, COEFF_W'($urandom));
         end
         run_random_phase(PHASE_ITEMS);
         drain_levels();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
